>>> rtl/core/block_cipher_padding_codec_unit_macros.svh
// ----------------------------------------------------------------------------
// Block cipher padding codec - assertion macros
// Concurrent assertion shorthands clocked on i_clk, disabled during reset.
// ----------------------------------------------------------------------------
`ifndef BLOCK_CIPHER_PADDING_CODEC_UNIT_MACROS_SVH
`define BLOCK_CIPHER_PADDING_CODEC_UNIT_MACROS_SVH

// Same-cycle implication
`define BPC_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication
`define BPC_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/core/bpc_pkg.sv
// ----------------------------------------------------------------------------
// bpc_pkg
// Shared constants, codes and types of the block cipher padding codec.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package bpc_pkg;

    // Block geometry
    localparam int MAX_BLOCK_BYTES = 16;
    localparam int SIZE_LIMIT      = (MAX_BLOCK_BYTES < 16) ? MAX_BLOCK_BYTES : 16;
    localparam int BLK_BYTES       = 16;
    localparam int LEN_W           = 5;
    localparam int IDX_W           = 4;

    // Configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 8;

    localparam logic [CFG_IDX_W-1:0] CFG_PAD_MODE       = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_BYTES    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_REMOVE_PADDING = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_XTS_CIPHER     = 3'd3;

    // Padding modes (codes above PAD_PKCS7 are invalid in pad direction)
    localparam logic [2:0] PAD_NONE    = 3'd0;
    localparam logic [2:0] PAD_ZEROS   = 3'd1;
    localparam logic [2:0] PAD_ISO7816 = 3'd2;
    localparam logic [2:0] PAD_X923    = 3'd3;
    localparam logic [2:0] PAD_PKCS5   = 3'd4;
    localparam logic [2:0] PAD_PKCS7   = 3'd5;

    // Status codes
    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_LEN_ERR = 2'd1;
    localparam logic [1:0] ST_BAD_PAD = 2'd2;
    localparam logic [1:0] ST_MODE    = 2'd3;

    // ISO 7816-4 marker byte
    localparam logic [7:0] ISO_MARK = 8'h80;

    typedef logic [BLK_BYTES-1:0][7:0] t_byte_vec;
    typedef logic [BLK_BYTES-1:0]      t_byte_flags;

    // Result of the padding check in unpad direction
    typedef struct packed {
        logic             ok;
        logic [LEN_W-1:0] len;
    } t_unpad_res;

endpackage

>>> rtl/core/bpc_unpad_check.sv
// ----------------------------------------------------------------------------
// bpc_unpad_check
// Checks ISO 7816-4, X.923 and PKCS padding of a decrypted block and gives
// the recovered plaintext length.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bpc_unpad_check (
    input  bpc_pkg::t_byte_vec             i_bytes,
    input  bpc_pkg::t_byte_flags           i_nonzero,
    input  bpc_pkg::t_byte_flags           i_is_mark,
    input  logic [7:0]                     i_count,
    input  logic [bpc_pkg::LEN_W-1:0]      i_block_bytes,
    input  logic [2:0]                     i_pad_mode,
    output bpc_pkg::t_unpad_res            o_res
);
    import bpc_pkg::*;

    logic [IDX_W-1:0] w_last_nz;
    logic             w_found;
    logic             w_count_bad;
    logic [LEN_W-1:0] w_pos;
    logic [LEN_W-1:0] w_bs_m1;
    logic             w_bad_x923;
    logic             w_bad_pkcs;

    // Highest nonzero byte inside the block (nonzero flags already masked)
    always_comb begin
        w_last_nz = '0;
        w_found   = 1'b0;
        for (int i = 0; i < BLK_BYTES; i++) begin
            if (i_nonzero[i]) begin
                w_last_nz = IDX_W'(i);
                w_found   = 1'b1;
            end
        end
    end

    // Count byte checks for X.923 and PKCS
    assign w_count_bad = (i_count == 8'd0) || (i_count > {3'd0, i_block_bytes});
    assign w_pos       = i_block_bytes - i_count[LEN_W-1:0];
    assign w_bs_m1     = i_block_bytes - 5'd1;

    always_comb begin
        w_bad_x923 = 1'b0;
        w_bad_pkcs = 1'b0;
        for (int i = 0; i < BLK_BYTES; i++) begin
            if ((LEN_W'(i) >= w_pos) && (LEN_W'(i) < i_block_bytes)) begin
                if ((LEN_W'(i) != w_bs_m1) && (i_bytes[i] != 8'd0)) begin
                    w_bad_x923 = 1'b1;
                end
                if (i_bytes[i] != i_count) begin
                    w_bad_pkcs = 1'b1;
                end
            end
        end
    end

    // Per-mode verdict
    always_comb begin
        case (i_pad_mode)
            PAD_ISO7816: begin
                o_res.ok  = w_found && i_is_mark[w_last_nz];
                o_res.len = {1'b0, w_last_nz};
            end
            PAD_X923: begin
                o_res.ok  = !w_count_bad && !w_bad_x923;
                o_res.len = w_pos;
            end
            default: begin
                o_res.ok  = !w_count_bad && !w_bad_pkcs;
                o_res.len = w_pos;
            end
        endcase
    end

endmodule

>>> rtl/core/block_cipher_padding_codec_unit.sv
// ----------------------------------------------------------------------------
// block_cipher_padding_codec_unit
// Final-block padding and padding check for a block cipher datapath.
// ----------------------------------------------------------------------------
// Usage:
//   Configuration channel (i_cfg_valid / o_cfg_ready, index, data) sets
//   pad_mode (0), block_bytes (1), remove_padding (2) and xts_cipher (3).
//   Write it only while no block is in flight; o_cfg_ready is always high.
//   Input channel (i_in_valid / o_in_ready) carries a 16-byte block as two
//   64-bit words plus the count of leading data bytes. Output channel
//   (o_out_valid / i_out_ready) returns the padded or unchanged block, the
//   padded or recovered length and a status code, one result per block.
//   From input transfer to o_out_valid a block passes four register stages:
//   capture, byte decode, padding build and check, result select.
//   One block per cycle while i_out_ready is high; each stage holds one block.
//   Reset clears the stage valid bits and loads the register defaults
//   (no padding, 16-byte block, pad direction, no XTS).
//   When the receiver stalls, each stage holds until the one after it frees
//   up; o_in_ready drops only once all four stages are full.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module block_cipher_padding_codec_unit (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // configuration
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [bpc_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [bpc_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    // input blocks
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  logic [63:0]                       i_block_high,
    input  logic [63:0]                       i_block_low,
    input  logic [bpc_pkg::LEN_W-1:0]         i_valid_bytes,
    // results
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output logic [63:0]                       o_result_high,
    output logic [63:0]                       o_result_low,
    output logic [bpc_pkg::LEN_W-1:0]         o_result_length,
    output logic [1:0]                        o_status
);
    import bpc_pkg::*;

    `include "block_cipher_padding_codec_unit_macros.svh"

    // Configuration registers
    logic [2:0]       r_pad_mode;
    logic [LEN_W-1:0] r_block_bytes;
    logic             r_remove_padding;
    logic             r_xts_cipher;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pad_mode       <= PAD_NONE;
            r_block_bytes    <= LEN_W'(BLK_BYTES);
            r_remove_padding <= 1'b0;
            r_xts_cipher     <= 1'b0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_PAD_MODE:       r_pad_mode       <= i_cfg_data[2:0];
                CFG_BLOCK_BYTES:    r_block_bytes    <= i_cfg_data[LEN_W-1:0];
                CFG_REMOVE_PADDING: r_remove_padding <= i_cfg_data[0];
                CFG_XTS_CIPHER:     r_xts_cipher     <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // Stage handshake: a stage moves when it is empty or the next one moves
    logic w_rdy1, w_rdy2, w_rdy3, w_rdy4;
    logic r1_v, r2_v, r3_v, r4_v;

    assign w_rdy4     = !r4_v || i_out_ready;
    assign w_rdy3     = !r3_v || w_rdy4;
    assign w_rdy2     = !r2_v || w_rdy3;
    assign w_rdy1     = !r1_v || w_rdy2;
    assign o_in_ready = w_rdy1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
            r2_v <= 1'b0;
            r3_v <= 1'b0;
            r4_v <= 1'b0;
        end else begin
            if (w_rdy1) r1_v <= i_in_valid;
            if (w_rdy2) r2_v <= r1_v;
            if (w_rdy3) r3_v <= r2_v;
            if (w_rdy4) r4_v <= r3_v;
        end
    end

    // ---------------- stage 1: capture ----------------
    t_byte_vec        n1_b;
    t_byte_vec        r1_b;
    logic [LEN_W-1:0] r1_vb;

    always_comb begin
        for (int i = 0; i < 8; i++) begin
            n1_b[i]     = i_block_high[63 - 8*i -: 8];
            n1_b[i + 8] = i_block_low[63 - 8*i -: 8];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && w_rdy1) begin
            r1_b  <= n1_b;
            r1_vb <= i_valid_bytes;
        end
    end

    // ---------------- stage 2: byte decode ----------------
    logic             n2_err_mode;
    logic             n2_err_len;
    logic [LEN_W-1:0] n2_bs_m1;
    t_byte_flags      n2_nz;
    t_byte_flags      n2_mark;
    t_byte_flags      n2_pmask;
    logic [LEN_W-1:0] n2_plen;

    t_byte_vec        r2_b;
    logic [LEN_W-1:0] r2_vb;
    logic [7:0]       r2_n;
    logic             r2_err_mode;
    logic             r2_err_len;
    t_byte_flags      r2_nz;
    t_byte_flags      r2_mark;
    t_byte_flags      r2_pmask;
    logic [LEN_W-1:0] r2_plen;

    assign n2_err_mode = !r_remove_padding && (r_pad_mode > PAD_PKCS7);
    assign n2_err_len  = (r_block_bytes == '0) || (r_block_bytes > LEN_W'(SIZE_LIMIT))
                         || (r1_vb > r_block_bytes);
    assign n2_bs_m1    = r_block_bytes - 5'd1;
    assign n2_plen     = r_block_bytes - r1_vb;

    always_comb begin
        for (int i = 0; i < BLK_BYTES; i++) begin
            n2_nz[i]    = (r1_b[i] != 8'd0) && (LEN_W'(i) < r_block_bytes);
            n2_mark[i]  = (r1_b[i] == ISO_MARK);
            n2_pmask[i] = (LEN_W'(i) >= r1_vb) && (LEN_W'(i) < r_block_bytes);
        end
    end

    always_ff @(posedge i_clk) begin
        if (r1_v && w_rdy2) begin
            r2_b        <= r1_b;
            r2_vb       <= r1_vb;
            r2_n        <= r1_b[n2_bs_m1[IDX_W-1:0]];
            r2_err_mode <= n2_err_mode;
            r2_err_len  <= n2_err_len;
            r2_nz       <= n2_nz;
            r2_mark     <= n2_mark;
            r2_pmask    <= n2_pmask;
            r2_plen     <= n2_plen;
        end
    end

    // ---------------- stage 3: pad build and padding check ----------------
    t_byte_vec        n3_pblk;
    logic [LEN_W-1:0] n3_bs_m1;
    t_unpad_res       n3_unpad;
    logic             n3_full_err;
    logic             n3_part_err;

    t_byte_vec        r3_b;
    t_byte_vec        r3_pblk;
    logic [LEN_W-1:0] r3_vb;
    t_unpad_res       r3_unpad;
    logic             r3_err_mode;
    logic             r3_err_len;
    logic             r3_full_err;
    logic             r3_part_err;

    assign n3_bs_m1 = r_block_bytes - 5'd1;

    // Tail fill for the pad direction
    always_comb begin
        for (int i = 0; i < BLK_BYTES; i++) begin
            n3_pblk[i] = r2_b[i];
            if (r2_pmask[i]) begin
                case (r_pad_mode)
                    PAD_PKCS5, PAD_PKCS7: n3_pblk[i] = {3'd0, r2_plen};
                    PAD_ISO7816: n3_pblk[i] = (LEN_W'(i) == r2_vb) ? ISO_MARK : 8'd0;
                    PAD_X923: n3_pblk[i] = (LEN_W'(i) == n3_bs_m1) ? {3'd0, r2_plen} : 8'd0;
                    default:  n3_pblk[i] = 8'd0;
                endcase
            end
        end
    end

    bpc_unpad_check u_unpad_check (
        .i_bytes       (r2_b),
        .i_nonzero     (r2_nz),
        .i_is_mark     (r2_mark),
        .i_count       (r2_n),
        .i_block_bytes (r_block_bytes),
        .i_pad_mode    (r_pad_mode),
        .o_res         (n3_unpad)
    );

    assign n3_full_err = (r_pad_mode != PAD_NONE) && (r2_vb >= r_block_bytes);
    assign n3_part_err = (r_pad_mode == PAD_NONE) && (r2_vb != '0)
                         && (r2_vb != r_block_bytes) && !r_xts_cipher;

    always_ff @(posedge i_clk) begin
        if (r2_v && w_rdy3) begin
            r3_b        <= r2_b;
            r3_pblk     <= n3_pblk;
            r3_vb       <= r2_vb;
            r3_unpad    <= n3_unpad;
            r3_err_mode <= r2_err_mode;
            r3_err_len  <= r2_err_len;
            r3_full_err <= n3_full_err;
            r3_part_err <= n3_part_err;
        end
    end

    // ---------------- stage 4: result select ----------------
    t_byte_vec        n4_blk;
    logic [LEN_W-1:0] n4_len;
    logic [1:0]       n4_st;

    t_byte_vec        r4_blk;
    logic [LEN_W-1:0] r4_len;
    logic [1:0]       r4_st;

    always_comb begin
        n4_blk = r3_b;
        n4_len = r3_vb;
        n4_st  = ST_OK;
        if (r3_err_mode) begin
            n4_st = ST_MODE;
        end else if (r3_err_len) begin
            n4_st = ST_LEN_ERR;
        end else if (!r_remove_padding) begin
            if (r_pad_mode == PAD_NONE) begin
                n4_st = r3_part_err ? ST_LEN_ERR : ST_OK;
            end else if (r3_full_err) begin
                n4_st = ST_LEN_ERR;
            end else begin
                n4_blk = r3_pblk;
                n4_len = r_block_bytes;
            end
        end else if (r_pad_mode inside {[PAD_ISO7816:PAD_PKCS7]}) begin
            if (r3_unpad.ok) begin
                n4_len = r3_unpad.len;
            end else begin
                n4_st  = ST_BAD_PAD;
                n4_len = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r3_v && w_rdy4) begin
            r4_blk <= n4_blk;
            r4_len <= n4_len;
            r4_st  <= n4_st;
        end
    end

    // Output packing
    always_comb begin
        for (int i = 0; i < 8; i++) begin
            o_result_high[63 - 8*i -: 8] = r4_blk[i];
            o_result_low[63 - 8*i -: 8]  = r4_blk[i + 8];
        end
    end

    assign o_out_valid     = r4_v;
    assign o_result_length = r4_len;
    assign o_status        = r4_st;

    // Checks
    `BPC_ASSERT_NXT(a_capture, i_in_valid && o_in_ready, r1_v, "accepted block not captured")
    `BPC_ASSERT_IMP(a_full_stall, r1_v && r2_v && r3_v && r4_v && !i_out_ready, !o_in_ready, "input taken with all stages full")
    `BPC_ASSERT_IMP(a_bad_len, o_out_valid && (o_status == ST_BAD_PAD), o_result_length == '0, "bad padding with nonzero length")

endmodule
